// ----- design/scs_pkg.sv -----
// Shared types and constants for the send command sequencer.
// Used by scs_ctrl, scs_datapath and send_command_sequencer_unit.
package scs_pkg;

    localparam int CNT_W = 3;

    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_CTRL_REL = 2'd1;
    localparam logic [1:0] REQ_CTRL_UNSEQ = 2'd2;

    localparam logic [7:0] CFG_CHANNEL_COUNT = 8'd0;
    localparam logic [7:0] CFG_FRAG_PAYLOAD  = 8'd1;
    localparam logic [7:0] CFG_MAX_PACKET    = 8'd2;
    localparam logic [7:0] CFG_PEER_CONN     = 8'd3;

    localparam logic [2:0] KIND_RELIABLE   = 3'd0;
    localparam logic [2:0] KIND_UNRELIABLE = 3'd1;
    localparam logic [2:0] KIND_UNSEQ      = 3'd2;
    localparam logic [2:0] KIND_REL_FRAG   = 3'd3;
    localparam logic [2:0] KIND_UNREL_FRAG = 3'd4;
    localparam logic [2:0] KIND_CONTROL    = 3'd5;

    localparam logic [15:0] SEQ_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        CLS_REJECT,
        CLS_CONTROL,
        CLS_SINGLE,
        CLS_FRAG
    } cls_t;

    typedef struct packed {
        logic latch;
        logic check;
        logic div_step;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic div_done;
        logic last_frag;
    } dp_status_t;

endpackage

// ----- design/scs_ctrl.sv -----
// Controller state machine of the send command sequencer.
// Depends on scs_pkg; drives the datapath through ctl_cmd_t.
module scs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_stall,
    input  scs_pkg::dp_status_t   dp_status,
    output logic                  in_stall,
    output logic                  out_valid,
    output scs_pkg::ctl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        slot_free      = !out_valid_reg || !out_stall;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (dp_status.cls == scs_pkg::CLS_FRAG)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_DRAIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dp_status.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (dp_status.last_frag)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("fragment loaded over a waiting result");
    a_check_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> !out_valid_reg)
        else $error("request checked while a result is pending");
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && dp_status.div_done) |=> (state_reg == S_EMIT))
        else $error("division did not hand over to emission");
`endif

endmodule

// ----- design/scs_datapath.sv -----
// Datapath of the send command sequencer: configuration, sequence counters,
// fragment count divider and result registers. Depends on scs_pkg.
module scs_datapath
#(
    parameter int MAX_CHANNELS  = 16,
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scs_pkg::ctl_cmd_t     cmd,
    output scs_pkg::dp_status_t   dp_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic [1:0]            req_type,
    input  logic [7:0]            channel_index,
    input  logic [23:0]           data_length,
    input  logic                  want_reliable,
    input  logic                  want_unsequenced,
    input  logic                  want_unreliable_fragment,
    output logic                  status,
    output logic [2:0]            command_kind,
    output logic [15:0]           reliable_seq,
    output logic [15:0]           unreliable_seq,
    output logic [15:0]           unseq_group,
    output logic [15:0]           start_seq,
    output logic [5:0]            fragment_number,
    output logic [6:0]            fragment_count,
    output logic [23:0]           fragment_offset,
    output logic [23:0]           fragment_length,
    output logic                  last_of_run
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int QW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

    logic [7:0]  cc_reg;
    logic [12:0] payload_reg;
    logic [23:0] max_len_reg;
    logic        conn_reg;

    logic [1:0]  type_reg;
    logic [7:0]  ch_reg;
    logic [23:0] len_reg;
    logic        rel_f_reg;
    logic        unseq_f_reg;
    logic        ufrag_f_reg;

    logic [15:0] chan_rel_reg [MAX_CHANNELS];
    logic [15:0] chan_unrel_reg [MAX_CHANNELS];
    logic [15:0] ctrl_seq_reg;
    logic [15:0] group_reg;

    logic [23:0]      rem_reg;
    logic [23:0]      dvs_reg;
    logic [QW-1:0]    q_reg;
    logic [scs_pkg::CNT_W-1:0] div_cnt_reg;
    logic [23:0]      off_reg;
    logic [QW-1:0]    idx_reg;
    logic             run_unrel_reg;
    logic [15:0]      start_reg;

    logic        status_reg;
    logic [2:0]  kind_reg;
    logic [15:0] rel_out_reg;
    logic [15:0] unrel_out_reg;
    logic [15:0] grp_out_reg;
    logic [15:0] start_out_reg;
    logic [5:0]  num_out_reg;
    logic [6:0]  cnt_out_reg;
    logic [23:0] off_out_reg;
    logic [23:0] len_out_reg;
    logic        last_out_reg;

    logic [12:0]   pay;
    logic [CW-1:0] chi;
    logic [15:0]   cur_rel;
    logic [15:0]   cur_unrel;
    logic [15:0]   rel_next;
    logic [15:0]   unrel_next;
    logic [15:0]   ctrl_seq_next;
    logic [15:0]   group_next;
    logic [31:0]   frag_limit;
    logic          ch_bad;
    scs_pkg::cls_t cls;
    logic          single_unseq;
    logic          single_rel;
    logic          run_unrel_now;
    logic          div_ge;
    logic [23:0]   left_len;
    logic [23:0]   flen;

    always_comb
    begin
        pay           = (payload_reg == 13'd0) ? 13'd1 : payload_reg;
        chi           = ch_reg[CW-1:0];
        cur_rel       = chan_rel_reg[chi];
        cur_unrel     = chan_unrel_reg[chi];
        rel_next      = cur_rel + 16'd1;
        unrel_next    = cur_unrel + 16'd1;
        ctrl_seq_next = ctrl_seq_reg + 16'd1;
        group_next    = group_reg + 16'd1;
        frag_limit    = 32'(pay) * 32'(MAX_FRAGMENTS);
        ch_bad        = (ch_reg >= cc_reg) || (32'(ch_reg) >= 32'(MAX_CHANNELS));
        if (type_reg == scs_pkg::REQ_CTRL_REL || type_reg == scs_pkg::REQ_CTRL_UNSEQ)
        begin
            cls = scs_pkg::CLS_CONTROL;
        end
        else if (type_reg != scs_pkg::REQ_DATA || !conn_reg || ch_bad ||
                 len_reg > max_len_reg)
        begin
            cls = scs_pkg::CLS_REJECT;
        end
        else if (len_reg > 24'(pay))
        begin
            cls = (32'(len_reg) > frag_limit) ? scs_pkg::CLS_REJECT : scs_pkg::CLS_FRAG;
        end
        else
        begin
            cls = scs_pkg::CLS_SINGLE;
        end
        single_unseq  = unseq_f_reg && !rel_f_reg;
        single_rel    = rel_f_reg || (cur_unrel == scs_pkg::SEQ_LIMIT);
        run_unrel_now = !rel_f_reg && ufrag_f_reg && (cur_unrel != scs_pkg::SEQ_LIMIT);
        div_ge        = (rem_reg >= dvs_reg);
        left_len      = len_reg - off_reg;
        flen          = (left_len < 24'(pay)) ? left_len : 24'(pay);
    end

    assign dp_status.cls       = cls;
    assign dp_status.div_done  = (div_cnt_reg == scs_pkg::CNT_W'(QW - 1));
    assign dp_status.last_frag = (idx_reg == q_reg);
    assign cfg_ready           = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg       <= 8'd1;
            payload_reg  <= 13'd1364;
            max_len_reg  <= 24'hFFFFFF;
            conn_reg     <= 1'b1;
            ctrl_seq_reg <= '0;
            group_reg    <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                chan_rel_reg[i]   <= '0;
                chan_unrel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    scs_pkg::CFG_CHANNEL_COUNT: cc_reg      <= cfg_data[7:0];
                    scs_pkg::CFG_FRAG_PAYLOAD:  payload_reg <= cfg_data[12:0];
                    scs_pkg::CFG_MAX_PACKET:    max_len_reg <= cfg_data;
                    scs_pkg::CFG_PEER_CONN:     conn_reg    <= cfg_data[0];
                    default:                    ;
                endcase
            end
            if (cmd.check)
            begin
                case (cls)
                    scs_pkg::CLS_CONTROL:
                    begin
                        ctrl_seq_reg <= ctrl_seq_next;
                    end
                    scs_pkg::CLS_SINGLE:
                    begin
                        if (single_unseq)
                        begin
                            group_reg <= group_next;
                        end
                        else if (single_rel)
                        begin
                            chan_rel_reg[chi]   <= rel_next;
                            chan_unrel_reg[chi] <= '0;
                        end
                        else
                        begin
                            chan_unrel_reg[chi] <= unrel_next;
                        end
                    end
                    scs_pkg::CLS_FRAG:
                    begin
                        if (run_unrel_now)
                        begin
                            chan_unrel_reg[chi] <= unrel_next;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.emit && !run_unrel_reg)
            begin
                chan_rel_reg[chi]   <= rel_next;
                chan_unrel_reg[chi] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            type_reg    <= req_type;
            ch_reg      <= channel_index;
            len_reg     <= data_length;
            rel_f_reg   <= want_reliable;
            unseq_f_reg <= want_unsequenced;
            ufrag_f_reg <= want_unreliable_fragment;
        end
        if (cmd.check)
        begin
            rem_reg       <= len_reg - 24'd1;
            dvs_reg       <= 24'(pay) << (QW - 1);
            q_reg         <= '0;
            div_cnt_reg   <= '0;
            off_reg       <= '0;
            idx_reg       <= '0;
            run_unrel_reg <= run_unrel_now;
            start_reg     <= run_unrel_now ? unrel_next : rel_next;
            status_reg    <= 1'b0;
            kind_reg      <= scs_pkg::KIND_RELIABLE;
            rel_out_reg   <= '0;
            unrel_out_reg <= '0;
            grp_out_reg   <= '0;
            start_out_reg <= '0;
            num_out_reg   <= '0;
            cnt_out_reg   <= '0;
            off_out_reg   <= '0;
            len_out_reg   <= '0;
            last_out_reg  <= 1'b1;
            case (cls)
                scs_pkg::CLS_REJECT:
                begin
                    status_reg <= 1'b1;
                end
                scs_pkg::CLS_CONTROL:
                begin
                    kind_reg    <= scs_pkg::KIND_CONTROL;
                    rel_out_reg <= ctrl_seq_next;
                end
                scs_pkg::CLS_SINGLE:
                begin
                    len_out_reg <= len_reg;
                    if (single_unseq)
                    begin
                        kind_reg    <= scs_pkg::KIND_UNSEQ;
                        grp_out_reg <= group_next;
                    end
                    else if (single_rel)
                    begin
                        kind_reg    <= scs_pkg::KIND_RELIABLE;
                        rel_out_reg <= rel_next;
                    end
                    else
                    begin
                        kind_reg      <= scs_pkg::KIND_UNRELIABLE;
                        rel_out_reg   <= cur_rel;
                        unrel_out_reg <= unrel_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg       <= QW'({q_reg, div_ge});
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg + scs_pkg::CNT_W'(1);
        end
        if (cmd.emit)
        begin
            status_reg    <= 1'b0;
            grp_out_reg   <= '0;
            start_out_reg <= start_reg;
            num_out_reg   <= 6'(idx_reg);
            cnt_out_reg   <= 7'(q_reg) + 7'd1;
            off_out_reg   <= off_reg;
            len_out_reg   <= flen;
            last_out_reg  <= (idx_reg == q_reg);
            off_reg       <= off_reg + 24'(pay);
            idx_reg       <= idx_reg + QW'(1);
            if (run_unrel_reg)
            begin
                kind_reg      <= scs_pkg::KIND_UNREL_FRAG;
                rel_out_reg   <= cur_rel;
                unrel_out_reg <= cur_unrel;
            end
            else
            begin
                kind_reg      <= scs_pkg::KIND_REL_FRAG;
                rel_out_reg   <= rel_next;
                unrel_out_reg <= '0;
            end
        end
    end

    assign status          = status_reg;
    assign command_kind    = kind_reg;
    assign reliable_seq    = rel_out_reg;
    assign unreliable_seq  = unrel_out_reg;
    assign unseq_group     = grp_out_reg;
    assign start_seq       = start_out_reg;
    assign fragment_number = num_out_reg;
    assign fragment_count  = cnt_out_reg;
    assign fragment_offset = off_out_reg;
    assign fragment_length = len_out_reg;
    assign last_of_run     = last_out_reg;

endmodule

// ----- design/send_command_sequencer_unit.sv -----
// Top level of the send command sequencer.
// Instantiates scs_ctrl and scs_datapath; depends on scs_pkg.
//
// A send request enters on the input channel when in_valid is high and
// in_stall is low; the block then stalls its input until every result of
// that request has been taken. Each result leaves through one output
// register on the output channel, taken when out_valid is high and
// out_stall is low; last_of_run marks the final result of a request.
// A rejected request, a control request and an unfragmented packet give
// one result, registered in the S_CHECK state that follows acceptance; the
// input is free again at the edge that takes that result. A fragmented
// packet first runs a restoring divider, one quotient bit a cycle (six
// bits at 64 fragments), then, while the receiver does not stall, gives
// one fragment a cycle. While the receiver stalls, the pending result
// holds and fragment emission pauses. Configuration writes are always
// ready and take effect at once. Reset clears all sequence counters and
// loads the register defaults; no clearing pass is needed.
module send_command_sequencer_unit
#(
    parameter int MAX_CHANNELS  = 16,
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  channel_index,
    input  logic [23:0] data_length,
    input  logic        want_reliable,
    input  logic        want_unsequenced,
    input  logic        want_unreliable_fragment,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [2:0]  command_kind,
    output logic [15:0] reliable_seq,
    output logic [15:0] unreliable_seq,
    output logic [15:0] unseq_group,
    output logic [15:0] start_seq,
    output logic [5:0]  fragment_number,
    output logic [6:0]  fragment_count,
    output logic [23:0] fragment_offset,
    output logic [23:0] fragment_length,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    scs_pkg::ctl_cmd_t   cmd;
    scs_pkg::dp_status_t dp_status;

    scs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    scs_datapath
    #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    )
    u_datapath
    (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cmd                      (cmd),
        .dp_status                (dp_status),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data),
        .req_type                 (req_type),
        .channel_index            (channel_index),
        .data_length              (data_length),
        .want_reliable            (want_reliable),
        .want_unsequenced         (want_unsequenced),
        .want_unreliable_fragment (want_unreliable_fragment),
        .status                   (status),
        .command_kind             (command_kind),
        .reliable_seq             (reliable_seq),
        .unreliable_seq           (unreliable_seq),
        .unseq_group              (unseq_group),
        .start_seq                (start_seq),
        .fragment_number          (fragment_number),
        .fragment_count           (fragment_count),
        .fragment_offset          (fragment_offset),
        .fragment_length          (fragment_length),
        .last_of_run              (last_of_run)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for send_command_sequencer_unit.
// Predicts every outgoing command descriptor with a scoreboard class and checks
// each result in order; depends on scs_pkg and the unit's RTL.
module tb_top;

    localparam int NCH  = 16;
    localparam int NFRG = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic        status;
        logic [2:0]  kind;
        logic [15:0] rel;
        logic [15:0] unrel;
        logic [15:0] grp;
        logic [15:0] start;
        logic [5:0]  num;
        logic [6:0]  cnt;
        logic [23:0] off;
        logic [23:0] len;
        logic        last;
    } command_t;

    class command_scoreboard;
        logic [7:0]  channel_count;
        logic [12:0] fragment_payload;
        logic [23:0] max_packet_size;
        logic        peer_connected;
        logic [15:0] rel_seq[NCH];
        logic [15:0] unrel_seq[NCH];
        logic [15:0] ctrl_seq;
        logic [15:0] unseq_grp;
        command_t    pending[$];
        int          errors;
        int          checked;

        function new();
            channel_count = 1;
            fragment_payload = 1364;
            max_packet_size = 24'hFFFFFF;
            peer_connected = 1;
            foreach (rel_seq[i])
            begin
                rel_seq[i] = 0;
                unrel_seq[i] = 0;
            end
            ctrl_seq = 0;
            unseq_grp = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void queue_result(command_t c);
            pending = {pending, c};
        endfunction

        function void note_config(logic [7:0] idx, logic [23:0] data);
            case (idx)
                scs_pkg::CFG_CHANNEL_COUNT: channel_count = data[7:0];
                scs_pkg::CFG_FRAG_PAYLOAD:  fragment_payload = data[12:0];
                scs_pkg::CFG_MAX_PACKET:    max_packet_size = data;
                scs_pkg::CFG_PEER_CONN:     peer_connected = data[0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] ch, logic [23:0] ln,
                                   logic rf, logic uf, logic ff);
            command_t c;
            int unsigned pay, cnt, off, flen;
            logic unrel_run;
            logic [15:0] st;
            c = '0;
            c.last = 1;
            if (rt == scs_pkg::REQ_CTRL_REL || rt == scs_pkg::REQ_CTRL_UNSEQ)
            begin
                ctrl_seq = ctrl_seq + 16'd1;
                c.kind = scs_pkg::KIND_CONTROL;
                c.rel = ctrl_seq;
                queue_result(c);
                return;
            end
            if (rt != scs_pkg::REQ_DATA || !peer_connected || ch >= channel_count
                || ch >= NCH || ln > max_packet_size)
            begin
                c.status = 1;
                queue_result(c);
                return;
            end
            pay = (fragment_payload == 0) ? 1 : 32'(fragment_payload);
            if (ln > pay)
            begin
                cnt = (ln + pay - 1) / pay;
                if (cnt > NFRG)
                begin
                    c.status = 1;
                    queue_result(c);
                    return;
                end
                unrel_run = !rf && ff && unrel_seq[ch] != scs_pkg::SEQ_LIMIT;
                if (unrel_run)
                begin
                    unrel_seq[ch] = unrel_seq[ch] + 16'd1;
                    st = unrel_seq[ch];
                end
                else
                    st = rel_seq[ch] + 16'd1;
                off = 0;
                for (int unsigned i = 0; i < cnt; i++)
                begin
                    flen = (ln - off < pay) ? ln - off : pay;
                    c = '0;
                    if (unrel_run)
                    begin
                        c.kind = scs_pkg::KIND_UNREL_FRAG;
                        c.unrel = unrel_seq[ch];
                    end
                    else
                    begin
                        rel_seq[ch] = rel_seq[ch] + 16'd1;
                        unrel_seq[ch] = 0;
                        c.kind = scs_pkg::KIND_REL_FRAG;
                    end
                    c.rel = rel_seq[ch];
                    c.start = st;
                    c.num = 6'(i);
                    c.cnt = 7'(cnt);
                    c.off = 24'(off);
                    c.len = 24'(flen);
                    c.last = (i + 1 == cnt);
                    queue_result(c);
                    off += pay;
                end
                return;
            end
            c.len = ln;
            if (uf && !rf)
            begin
                unseq_grp = unseq_grp + 16'd1;
                c.kind = scs_pkg::KIND_UNSEQ;
                c.grp = unseq_grp;
            end
            else if (rf || unrel_seq[ch] == scs_pkg::SEQ_LIMIT)
            begin
                rel_seq[ch] = rel_seq[ch] + 16'd1;
                unrel_seq[ch] = 0;
                c.kind = scs_pkg::KIND_RELIABLE;
                c.rel = rel_seq[ch];
            end
            else
            begin
                unrel_seq[ch] = unrel_seq[ch] + 16'd1;
                c.kind = scs_pkg::KIND_UNRELIABLE;
                c.rel = rel_seq[ch];
                c.unrel = unrel_seq[ch];
            end
            queue_result(c);
        endfunction

        function void check_result(command_t got);
            command_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: no request pending");
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.kind !== e.kind)
            begin
                $error("command_kind exp %0d got %0d", e.kind, got.kind); errors++;
            end
            if (got.rel !== e.rel)
            begin
                $error("reliable_seq exp %0d got %0d", e.rel, got.rel); errors++;
            end
            if (got.unrel !== e.unrel)
            begin
                $error("unreliable_seq exp %0d got %0d", e.unrel, got.unrel); errors++;
            end
            if (got.grp !== e.grp)
            begin
                $error("unseq_group exp %0d got %0d", e.grp, got.grp); errors++;
            end
            if (got.start !== e.start)
            begin
                $error("start_seq exp %0d got %0d", e.start, got.start); errors++;
            end
            if (got.num !== e.num)
            begin
                $error("fragment_number exp %0d got %0d", e.num, got.num); errors++;
            end
            if (got.cnt !== e.cnt)
            begin
                $error("fragment_count exp %0d got %0d", e.cnt, got.cnt); errors++;
            end
            if (got.off !== e.off)
            begin
                $error("fragment_offset exp %0d got %0d", e.off, got.off); errors++;
            end
            if (got.len !== e.len)
            begin
                $error("fragment_length exp %0d got %0d", e.len, got.len); errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last_of_run exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] req_type = 0;
    logic [7:0] channel_index = 0;
    logic [23:0] data_length = 0;
    logic want_reliable = 0;
    logic want_unsequenced = 0;
    logic want_unreliable_fragment = 0;
    logic out_valid;
    logic out_stall = 0;
    logic status;
    logic [2:0] command_kind;
    logic [15:0] reliable_seq, unreliable_seq, unseq_group, start_seq;
    logic [5:0] fragment_number;
    logic [6:0] fragment_count;
    logic [23:0] fragment_offset, fragment_length;
    logic last_of_run;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [7:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;

    command_scoreboard sb;
    int idle_pct = 23;
    int requests = 0;
    int quiet_cycles = 0;

    send_command_sequencer_unit u_dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, command_kind, reliable_seq, unreliable_seq,
                             unseq_group, start_seq, fragment_number, fragment_count,
                             fragment_offset, fragment_length, last_of_run});
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [23:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.note_config(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_request(logic [1:0] rt, logic [7:0] ch, logic [23:0] ln,
                                logic rf, logic uf, logic ff);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        in_valid <= 1;
        req_type <= rt;
        channel_index <= ch;
        data_length <= ln;
        want_reliable <= rf;
        want_unsequenced <= uf;
        want_unreliable_fragment <= ff;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(rt, ch, ln, rf, uf, ff);
        requests++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic random_request();
        logic [1:0] rt;
        logic [23:0] ln;
        logic [7:0] ch;
        int r;
        r = $urandom_range(99);
        rt = (r < 75) ? scs_pkg::REQ_DATA : (r < 85) ? scs_pkg::REQ_CTRL_REL
             : (r < 95) ? scs_pkg::REQ_CTRL_UNSEQ : REQ_UNKNOWN;
        r = $urandom_range(99);
        if (r < 50)
            ln = 24'($urandom_range(sb.fragment_payload));
        else if (r < 85)
            ln = 24'($urandom_range(sb.fragment_payload * 12 + 1));
        else if (r < 95)
            ln = 24'($urandom_range(sb.fragment_payload * 70 + 1));
        else
            ln = 24'($urandom);
        ch = 8'(($urandom_range(99) < 85) ? $urandom_range(sb.channel_count)
                : $urandom_range(255));
        send_request(rt, ch, ln, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_request(scs_pkg::REQ_DATA, 0, 0, 0, 0, 0);
        send_request(scs_pkg::REQ_DATA, 0, 100, 1, 0, 0);
        send_request(scs_pkg::REQ_DATA, 0, 100, 0, 1, 0);
        send_request(scs_pkg::REQ_DATA, 0, 1364, 0, 1, 1);
        send_request(scs_pkg::REQ_DATA, 0, 1365, 0, 0, 1);
        send_request(scs_pkg::REQ_DATA, 0, 24'(1365 * 3), 1, 0, 1);
        send_request(scs_pkg::REQ_DATA, 0, 24'(1364 * 64), 0, 0, 0);
        send_request(scs_pkg::REQ_DATA, 0, 24'(1364 * 64 + 1), 0, 0, 0);
        send_request(scs_pkg::REQ_DATA, 0, 24'hFFFFFF, 1, 1, 1);
        send_request(scs_pkg::REQ_DATA, 1, 10, 1, 0, 0);
        send_request(scs_pkg::REQ_DATA, 255, 10, 1, 0, 0);
        send_request(scs_pkg::REQ_CTRL_REL, 8'hFF, 24'hFFFFFF, 1, 1, 1);
        send_request(scs_pkg::REQ_CTRL_UNSEQ, 0, 0, 0, 0, 0);
        send_request(REQ_UNKNOWN, 0, 5, 1, 0, 0);
        wait_idle();
        write_reg(scs_pkg::CFG_PEER_CONN, 0);
        send_request(scs_pkg::REQ_DATA, 0, 5, 1, 0, 0);
        send_request(scs_pkg::REQ_CTRL_REL, 0, 5, 0, 0, 0);
        wait_idle();
        write_reg(scs_pkg::CFG_PEER_CONN, 1);
        write_reg(scs_pkg::CFG_CHANNEL_COUNT, 255);
        write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 0);
        write_reg(scs_pkg::CFG_MAX_PACKET, 64);
        send_request(scs_pkg::REQ_DATA, 15, 64, 0, 0, 1);
        send_request(scs_pkg::REQ_DATA, 15, 65, 0, 0, 1);
        send_request(scs_pkg::REQ_DATA, 16, 3, 1, 0, 0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(scs_pkg::CFG_CHANNEL_COUNT, 16);
                    write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 4096);
                    write_reg(scs_pkg::CFG_MAX_PACKET, 24'hFFFFFF);
                end
                1:
                begin
                    write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 8191);
                    write_reg(scs_pkg::CFG_CHANNEL_COUNT, 1);
                end
                2:
                begin
                    write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 1);
                    write_reg(scs_pkg::CFG_CHANNEL_COUNT, 4);
                    write_reg(scs_pkg::CFG_MAX_PACKET, 40);
                end
                3:
                begin
                    write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 24'($urandom_range(1, 300)));
                    write_reg(scs_pkg::CFG_MAX_PACKET, 0);
                    write_reg(scs_pkg::CFG_CHANNEL_COUNT, 8);
                end
                4:
                begin
                    write_reg(scs_pkg::CFG_MAX_PACKET, 24'($urandom_range(1000, 24'hFFFFFF)));
                    write_reg(scs_pkg::CFG_PEER_CONN, 24'($urandom_range(1)));
                end
                default:
                begin
                    write_reg(scs_pkg::CFG_PEER_CONN, 1);
                    write_reg(scs_pkg::CFG_CHANNEL_COUNT, 16);
                    write_reg(scs_pkg::CFG_FRAG_PAYLOAD, 1364);
                end
            endcase
            idle_pct = (ph == 5) ? 0 : 23;
            for (int k = 0; k < 25; k++)
                random_request();
            wait_idle();
        end
        idle_pct = 23;
        $display("Sent %0d requests, checked %0d results across several register settings.",
                 requests, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/scs_pkg.sv
design/scs_ctrl.sv
design/scs_datapath.sv
design/send_command_sequencer_unit.sv
sim/tb_top.sv
